// ===== design/aabb_rt_pkg.sv =====
// Package with the shared types, constants and helper functions of the box transform.
`timescale 1ns / 1ps

package aabb_rt_pkg;

    typedef logic signed [15:0] rot_t;
    typedef logic signed [31:0] coord_t;
    typedef logic signed [47:0] prod_t;
    typedef logic signed [33:0] term_t;
    typedef logic signed [35:0] acc_t;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_BASE_MIN_X = 3'd0;
    localparam reg_index_t REG_BASE_MIN_Y = 3'd1;
    localparam reg_index_t REG_BASE_MIN_Z = 3'd2;
    localparam reg_index_t REG_BASE_MAX_X = 3'd3;
    localparam reg_index_t REG_BASE_MAX_Y = 3'd4;
    localparam reg_index_t REG_BASE_MAX_Z = 3'd5;

    localparam int PROD_SHIFT = 14;

    localparam acc_t SAT_HI = 36'sh0_7FFF_FFFF;
    localparam acc_t SAT_LO = 36'shF_8000_0000;

    typedef rot_t [2:0][2:0] rot_mat_t;
    typedef coord_t [2:0] coord_vec_t;

    typedef struct packed {
        prod_t [2:0][2:0] p_lo;
        prod_t [2:0][2:0] p_hi;
        coord_vec_t       move;
    } mul_data_t;

    typedef struct packed {
        term_t [2:0][2:0] t_lo;
        term_t [2:0][2:0] t_hi;
        coord_vec_t       move;
    } sel_data_t;

    typedef struct packed {
        acc_t [2:0] lo;
        acc_t [2:0] hi;
    } sum_data_t;

    typedef struct packed {
        coord_vec_t lo;
        coord_vec_t hi;
    } box_t;

    function automatic prod_t mul_q14(input rot_t r, input coord_t c);
        prod_t p;
        p = prod_t'(r) * prod_t'(c);
        return p;
    endfunction

    function automatic term_t shift_q14(input prod_t p);
        return term_t'(p >>> PROD_SHIFT);
    endfunction

    function automatic coord_t sat32(input acc_t a);
        coord_t c;
        if ($signed(a) > $signed(SAT_HI))
            c = coord_t'(SAT_HI[31:0]);
        else if ($signed(a) < $signed(SAT_LO))
            c = coord_t'(SAT_LO[31:0]);
        else
            c = coord_t'(a[31:0]);
        return c;
    endfunction

endpackage

// ===== design/aabb_rt_mul.sv =====
// First pipeline stage: the eighteen matrix by base corner products.
`timescale 1ns / 1ps

module aabb_rt_mul
    import aabb_rt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rot_mat_t   rot,
    input  coord_vec_t move,
    input  coord_vec_t base_lo,
    input  coord_vec_t base_hi,
    output logic       out_valid,
    input  logic       out_ready,
    output mul_data_t  out_data
);

    logic      valid_reg;
    logic      valid_next;
    mul_data_t data_reg;
    mul_data_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next.move = move;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                data_next.p_lo[i][j] = mul_q14(rot[i][j], base_lo[j]);
                data_next.p_hi[i][j] = mul_q14(rot[i][j], base_hi[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// ===== design/aabb_rt_select.sv =====
// Second pipeline stage: product truncation and per-column min and max selection.
`timescale 1ns / 1ps

module aabb_rt_select
    import aabb_rt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mul_data_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output sel_data_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    sel_data_t data_reg;
    sel_data_t data_next;
    term_t     e;
    term_t     f;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next.move = in_data.move;
        e = '0;
        f = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e = shift_q14(in_data.p_lo[i][j]);
                f = shift_q14(in_data.p_hi[i][j]);
                if ($signed(e) < $signed(f))
                begin
                    data_next.t_lo[i][j] = e;
                    data_next.t_hi[i][j] = f;
                end
                else
                begin
                    data_next.t_lo[i][j] = f;
                    data_next.t_hi[i][j] = e;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// ===== design/aabb_rt_sum.sv =====
// Third pipeline stage: exact sums of translation and selected terms per axis.
`timescale 1ns / 1ps

module aabb_rt_sum
    import aabb_rt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sel_data_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output sum_data_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    sum_data_t data_reg;
    sum_data_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            data_next.lo[i] = acc_t'(in_data.move[i])
                            + acc_t'(in_data.t_lo[i][0])
                            + acc_t'(in_data.t_lo[i][1])
                            + acc_t'(in_data.t_lo[i][2]);
            data_next.hi[i] = acc_t'(in_data.move[i])
                            + acc_t'(in_data.t_hi[i][0])
                            + acc_t'(in_data.t_hi[i][1])
                            + acc_t'(in_data.t_hi[i][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// ===== design/aabb_rt_sat.sv =====
// Fourth pipeline stage: saturation to 32 bits into the result register.
`timescale 1ns / 1ps

module aabb_rt_sat
    import aabb_rt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sum_data_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output box_t      out_data
);

    logic valid_reg;
    logic valid_next;
    box_t data_reg;
    box_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            data_next.lo[i] = sat32(in_data.lo[i]);
            data_next.hi[i] = sat32(in_data.hi[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// ===== design/aabb_rotate_translate.sv =====
// Top level of the box transform: configuration registers and the four-stage pipeline.
//
// The block turns a stored base box into the axis-aligned box that encloses it after
// a 3x3 rotation and a translation. The base box sits in six configuration registers,
// written through the cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data); the
// channel is always ready, and indexes beyond the six registers are ignored. The base
// box should only be changed while no request is in flight.
// Each request on the req channel carries the matrix (rot_00 to rot_22, Q2.14) and
// the translation (move_x to move_z, Q16.16). The result on the res channel gives the
// enclosing box in Q16.16, saturated to 32 bits.
// A request passes the register stages of multiply, select, sum and saturate in that
// order before its result shows on the res channel. One request per cycle is taken
// and one result per cycle is given while the receiver does not stall; the eighteen
// products of the first stage are formed anew for each request.
// Reset clears the base box to zero and empties the pipeline. When the receiver
// stalls, the held stages stop in place while empty stages further up keep filling, so
// up to four requests are held before req_ready falls.
`timescale 1ns / 1ps

module aabb_rotate_translate
    import aabb_rt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         req_valid,
    output logic         req_ready,
    input  logic signed [15:0] rot_00,
    input  logic signed [15:0] rot_01,
    input  logic signed [15:0] rot_02,
    input  logic signed [15:0] rot_10,
    input  logic signed [15:0] rot_11,
    input  logic signed [15:0] rot_12,
    input  logic signed [15:0] rot_20,
    input  logic signed [15:0] rot_21,
    input  logic signed [15:0] rot_22,
    input  logic signed [31:0] move_x,
    input  logic signed [31:0] move_y,
    input  logic signed [31:0] move_z,
    output logic         res_valid,
    input  logic         res_ready,
    output logic signed [31:0] box_min_x,
    output logic signed [31:0] box_min_y,
    output logic signed [31:0] box_min_z,
    output logic signed [31:0] box_max_x,
    output logic signed [31:0] box_max_y,
    output logic signed [31:0] box_max_z
);

    coord_vec_t base_lo_reg;
    coord_vec_t base_lo_next;
    coord_vec_t base_hi_reg;
    coord_vec_t base_hi_next;

    rot_mat_t   rot;
    coord_vec_t move;

    logic      mul_valid;
    logic      mul_ready;
    mul_data_t mul_data;
    logic      sel_valid;
    logic      sel_ready;
    sel_data_t sel_data;
    logic      sum_valid;
    logic      sum_ready;
    sum_data_t sum_data;
    box_t      box;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_lo_next = base_lo_reg;
        base_hi_next = base_hi_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_MIN_X: base_lo_next[0] = coord_t'(cfg_data);
                REG_BASE_MIN_Y: base_lo_next[1] = coord_t'(cfg_data);
                REG_BASE_MIN_Z: base_lo_next[2] = coord_t'(cfg_data);
                REG_BASE_MAX_X: base_hi_next[0] = coord_t'(cfg_data);
                REG_BASE_MAX_Y: base_hi_next[1] = coord_t'(cfg_data);
                REG_BASE_MAX_Z: base_hi_next[2] = coord_t'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_lo_reg <= '0;
            base_hi_reg <= '0;
        end
        else
        begin
            base_lo_reg <= base_lo_next;
            base_hi_reg <= base_hi_next;
        end
    end

    always_comb
    begin
        rot[0][0] = rot_00;
        rot[0][1] = rot_01;
        rot[0][2] = rot_02;
        rot[1][0] = rot_10;
        rot[1][1] = rot_11;
        rot[1][2] = rot_12;
        rot[2][0] = rot_20;
        rot[2][1] = rot_21;
        rot[2][2] = rot_22;
        move[0]   = move_x;
        move[1]   = move_y;
        move[2]   = move_z;
    end

    aabb_rt_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .rot       (rot),
        .move      (move),
        .base_lo   (base_lo_reg),
        .base_hi   (base_hi_reg),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    aabb_rt_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .out_data  (sel_data)
    );

    aabb_rt_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_data   (sel_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    aabb_rt_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (box)
    );

    assign box_min_x = box.lo[0];
    assign box_min_y = box.lo[1];
    assign box_min_z = box.lo[2];
    assign box_max_x = box.hi[0];
    assign box_max_y = box.hi[1];
    assign box_max_z = box.hi[2];

    // The per-column selection keeps every result box well ordered.
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ($signed(box_min_x) <= $signed(box_max_x))
                   && ($signed(box_min_y) <= $signed(box_max_y))
                   && ($signed(box_min_z) <= $signed(box_max_z)))
        else $error("result box has min above max");

    // An empty first stage always takes a request.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !mul_valid |-> req_ready)
        else $error("first stage empty but request refused");

    // A full pipeline behind a stalled receiver must refuse requests.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_valid && sel_valid && sum_valid && res_valid && !res_ready) |-> !req_ready)
        else $error("request accepted into a full stalled pipeline");

    // A write to the base minimum x lands in its register.
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == REG_BASE_MIN_X)
        |=> base_lo_reg[0] == $past(cfg_data))
        else $error("base minimum x not updated by write");

endmodule
